@@ rtl/brbq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer queue package
// Shared sizes, operation and status codes, state and result types.
// ----------------------------------------------------------------------------
package brbq_pkg;

    localparam int DEPTH      = 1024;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int LEN_W      = $clog2(DEPTH + 1);
    localparam int READ_MAX   = 64;
    localparam int REMAIN_W   = $clog2(READ_MAX + 1);
    localparam int DATA_W     = 8;
    localparam int OP_W       = 2;
    localparam int COUNT_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int LEVEL_W    = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_POP  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } brbq_state_t;

    typedef struct packed {
        logic [DATA_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic [PTR_W-1:0]    occupancy;
    } brbq_result_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               pop;
    } brbq_qstat_t;

endpackage

@@ rtl/brbq_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer queue channel interfaces
// Valid and ready handshake channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface brbq_in_if;
    logic                          valid;
    logic                          ready;
    logic [brbq_pkg::OP_W-1:0]     op;
    logic [brbq_pkg::DATA_W-1:0]   data_in;
    logic                          run_first;
    logic [brbq_pkg::COUNT_W-1:0]  count;
    logic [brbq_pkg::PTR_W-1:0]    offset;

    modport source (output valid, op, data_in, run_first, count, offset, input ready);
    modport sink   (input valid, op, data_in, run_first, count, offset, output ready);
endinterface

interface brbq_out_if;
    logic                          valid;
    logic                          ready;
    logic [brbq_pkg::DATA_W-1:0]   data_out;
    logic [brbq_pkg::STATUS_W-1:0] status;
    logic                          last;
    logic [brbq_pkg::PTR_W-1:0]    occupancy;

    modport source (output valid, data_out, status, last, occupancy, input ready);
    modport sink   (input valid, data_out, status, last, occupancy, output ready);
endinterface

@@ rtl/brbq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer queue storage
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module brbq_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/brbq_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer queue result queue
// Two-entry result buffer that decouples the controller from the receiver.
// ----------------------------------------------------------------------------
module brbq_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  brbq_pkg::brbq_result_t push_data,
    output brbq_pkg::brbq_qstat_t  stat,
    brbq_out_if.source             out_ch
);
    import brbq_pkg::*;

    brbq_result_t       entry_reg [2];
    logic               head_reg;
    logic               head_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic               pop;
    logic               tail;

    assign pop  = out_ch.valid && out_ch.ready;
    assign tail = head_reg ^ level_reg[0];

    always_comb
    begin
        head_next  = head_reg ^ pop;
        level_next = level_reg + LEVEL_W'(push) - LEVEL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail] <= push_data;
        end
    end

    assign out_ch.valid     = (level_reg != '0);
    assign out_ch.data_out  = entry_reg[head_reg].data_out;
    assign out_ch.status    = entry_reg[head_reg].status;
    assign out_ch.last      = entry_reg[head_reg].last;
    assign out_ch.occupancy = entry_reg[head_reg].occupancy;

    assign stat.level = level_reg;
    assign stat.pop   = pop;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg != 2'd3)
        else $error("Result queue level out of range.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg == 2'd2 && !pop) |-> !push)
        else $error("Result queue written while full.");

endmodule

@@ rtl/brbq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer queue controller
// Pointer state, push, pop and read sequencing against the byte store.
// ----------------------------------------------------------------------------
module brbq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [brbq_pkg::LEN_W-1:0] cfg_wdata,
    brbq_in_if.sink                    in_ch,
    input  brbq_pkg::brbq_qstat_t      q_stat,
    output logic                       q_push,
    output brbq_pkg::brbq_result_t     q_data,
    output logic                       ram_we,
    output logic [brbq_pkg::PTR_W-1:0] ram_waddr,
    output logic [brbq_pkg::DATA_W-1:0] ram_wdata,
    output logic                       ram_re,
    output logic [brbq_pkg::PTR_W-1:0] ram_raddr,
    input  logic [brbq_pkg::DATA_W-1:0] ram_rdata
);
    import brbq_pkg::*;

    brbq_state_t         state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic                run_acc_reg, run_acc_next;
    logic [PTR_W-1:0]    raddr_reg, raddr_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic [PTR_W-1:0]    occ_hold_reg, occ_hold_next;
    logic                pend_reg, pend_next;
    logic                pend_last_reg, pend_last_next;

    logic [LEN_W-1:0]    occ_w;
    logic [PTR_W-1:0]    occ;
    logic [LEN_W-1:0]    space;
    logic [LEN_W-1:0]    wp_inc;
    logic [LEN_W-1:0]    start_w;
    logic [LEN_W-1:0]    rp_adv;
    logic [LEN_W-1:0]    raddr_inc;
    logic [PTR_W-1:0]    pop_n;
    logic [LEVEL_W-1:0]  avail;
    logic [LEVEL_W:0]    inflight;
    logic                accept;
    logic                push_ok;
    logic                read_bad;
    logic                issue;
    logic [LEN_W-1:0]    len_sat;

    always_comb
    begin
        occ_w = {1'b0, wp_reg} - {1'b0, rp_reg};
        if (wp_reg < rp_reg)
        begin
            occ_w = occ_w + len_reg;
        end
        occ   = occ_w[PTR_W-1:0];
        space = len_reg - LEN_W'(1) - {1'b0, occ};

        wp_inc = {1'b0, wp_reg} + LEN_W'(1);
        if (wp_inc == len_reg)
        begin
            wp_inc = '0;
        end

        start_w = {1'b0, rp_reg} + {1'b0, in_ch.offset};
        if (start_w >= len_reg)
        begin
            start_w = start_w - len_reg;
        end

        pop_n  = (in_ch.count < occ) ? in_ch.count : occ;
        rp_adv = {1'b0, rp_reg} + {1'b0, pop_n};
        if (rp_adv >= len_reg)
        begin
            rp_adv = rp_adv - len_reg;
        end

        raddr_inc = {1'b0, raddr_reg} + LEN_W'(1);
        if (raddr_inc == len_reg)
        begin
            raddr_inc = '0;
        end

        read_bad = (in_ch.count > COUNT_W'(READ_MAX))
                || (({1'b0, in_ch.offset} + {1'b0, in_ch.count}) > {1'b0, occ});

        if (cfg_wdata < LEN_W'(2))
        begin
            len_sat = LEN_W'(2);
        end
        else if (cfg_wdata > LEN_W'(DEPTH))
        begin
            len_sat = LEN_W'(DEPTH);
        end
        else
        begin
            len_sat = cfg_wdata;
        end
    end

    assign avail       = q_stat.level - LEVEL_W'(q_stat.pop);
    assign inflight    = {1'b0, avail} + (LEVEL_W+1)'(pend_reg);
    assign in_ch.ready = (state_reg == ST_IDLE) && !pend_reg && (avail != 2'd2);
    assign accept      = in_ch.valid && in_ch.ready;
    assign issue       = (state_reg == ST_READ) && (inflight < 3'd2);

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        run_acc_next   = run_acc_reg;
        raddr_next     = raddr_reg;
        remain_next    = remain_reg;
        occ_hold_next  = occ_hold_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        push_ok        = 1'b0;

        q_push         = 1'b0;
        q_data         = '0;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = in_ch.data_in;
        ram_re         = 1'b0;
        ram_raddr      = raddr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.op)
                        OP_PUSH:
                        begin
                            if (in_ch.run_first)
                            begin
                                run_acc_next = ({1'b0, in_ch.count} <= space);
                            end
                            push_ok          = run_acc_next && (space != '0);
                            q_push           = 1'b1;
                            q_data.last      = 1'b1;
                            if (push_ok)
                            begin
                                ram_we           = 1'b1;
                                wp_next          = wp_inc[PTR_W-1:0];
                                q_data.status    = STATUS_OK;
                                q_data.occupancy = occ + PTR_W'(1);
                            end
                            else
                            begin
                                q_data.status    = STATUS_REJECT;
                                q_data.occupancy = occ;
                            end
                        end
                        OP_READ:
                        begin
                            if (read_bad)
                            begin
                                q_push           = 1'b1;
                                q_data.status    = STATUS_RANGE;
                                q_data.last      = 1'b1;
                                q_data.occupancy = occ;
                            end
                            else if (in_ch.count != '0)
                            begin
                                state_next    = ST_READ;
                                raddr_next    = start_w[PTR_W-1:0];
                                remain_next   = in_ch.count[REMAIN_W-1:0];
                                occ_hold_next = occ;
                            end
                        end
                        OP_POP:
                        begin
                            rp_next          = rp_adv[PTR_W-1:0];
                            q_push           = 1'b1;
                            q_data.status    = STATUS_OK;
                            q_data.last      = 1'b1;
                            q_data.occupancy = occ - pop_n;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (issue)
                begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = (remain_reg == REMAIN_W'(1));
                    raddr_next     = raddr_inc[PTR_W-1:0];
                    remain_next    = remain_reg - REMAIN_W'(1);
                    if (remain_reg == REMAIN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (pend_reg)
        begin
            q_push           = 1'b1;
            q_data.data_out  = ram_rdata;
            q_data.status    = STATUS_OK;
            q_data.last      = pend_last_reg;
            q_data.occupancy = occ_hold_reg;
        end

        if (cfg_we)
        begin
            len_next     = len_sat;
            wp_next      = '0;
            rp_next      = '0;
            run_acc_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= LEN_W'(DEPTH);
            wp_reg      <= '0;
            rp_reg      <= '0;
            run_acc_reg <= 1'b0;
            remain_reg  <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            run_acc_reg <= run_acc_next;
            remain_reg  <= remain_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_reg     <= raddr_next;
        occ_hold_reg  <= occ_hold_next;
        pend_last_reg <= pend_last_next;
    end

    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wp_reg} < len_reg) && ({1'b0, rp_reg} < len_reg))
        else $error("Queue pointer beyond the buffer length.");

    a_read_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (remain_reg != '0))
        else $error("Read sequencer active with nothing left to fetch.");

    a_pend_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && pend_last_reg) |-> (state_reg == ST_IDLE))
        else $error("Final read beat fetched while the sequencer still runs.");

    a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !in_ch.ready)
        else $error("Request taken while a read beat is in flight.");

endmodule

@@ rtl/byte_ring_buffer_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer queue unit
// Byte FIFO with configurable length, all-or-nothing push runs, offset reads
// and clamped pops.
// ----------------------------------------------------------------------------
// Requests enter on in_ch and results leave on out_ch, both valid/ready
// channels; a beat moves when valid and ready are high at a clock edge.
// A push or pop beat gives one result beat, registered in the result queue,
// and the next request can be taken in the following cycle if the queue has room.
// A read of n bytes gives n result beats through the byte store's single
// registered read port and the result queue, one byte per cycle while the
// receiver keeps up; the next request waits until the last byte has left the port.
// A read that is out of range gives a single error beat like a push.
// A two-entry result queue sits in front of out_ch: when the receiver
// stalls, it fills and then holds in_ch ready low until space frees up.
// Writing cfg_wdata with cfg_we empties the queue and sets the length; it
// must only be done while the block is idle.
// Reset empties the queue and sets the length to the full store. The store
// itself is not cleared; only bytes that were pushed can be read back.
// ----------------------------------------------------------------------------
module byte_ring_buffer_queue_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [brbq_pkg::LEN_W-1:0] cfg_wdata,
    brbq_in_if.sink                    in_ch,
    brbq_out_if.source                 out_ch
);
    import brbq_pkg::*;

    brbq_qstat_t         q_stat;
    logic                q_push;
    brbq_result_t        q_data;
    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [PTR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    brbq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    brbq_ram #(
        .ADDR_W (PTR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brbq_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .stat      (q_stat),
        .out_ch    (out_ch)
    );

endmodule
